// ----- rtl/kle_pkg.sv -----
// Shared constants and controller/datapath interface types for the line editor.
package kle_pkg;

  localparam int unsigned LINE_CAPACITY_DEF = 64;

  localparam int unsigned KEY_W = 8;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [KEY_W-1:0] BACKSPACE_CODE_RST = 8'd45;  // '-'
  localparam logic [KEY_W-1:0] LEFT_CODE_RST = 8'd60;       // '<'
  localparam logic [KEY_W-1:0] RIGHT_CODE_RST = 8'd62;      // '>'

  localparam logic [CFG_IDX_W-1:0] CFG_BACKSPACE_CODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_CODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_CODE = 2'd2;

  // Controller -> datapath
  typedef struct packed {
    logic accept;      // input beat taken this cycle
    logic move_wr;     // second half of a cursor move: write the popped char
    logic emit_first;  // fetch the first char of the line
    logic emit_adv;    // output beat taken, fetch the next char
    logic finish;      // final output beat taken, clear the line
  } kle_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic move_ok;  // current key is a cursor move that will happen
    logic last;     // char on the output is the last of the line
  } kle_stat_t;

endpackage

// ----- rtl/kle_ctrl.sv -----
// Line editor sequencer: keystroke intake, cursor move completion and line emission.
module kle_ctrl
  import kle_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_line_end,
  input  logic      out_stall,
  input  kle_stat_t stat,
  output logic      in_stall,
  output logic      out_valid,
  output kle_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MOVE,
    S_START,
    S_SEND
  } state_t;

  state_t state_r, state_nxt;
  logic   line_end_r, line_end_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_SEND);

  always_comb begin
    cmd            = '0;
    cmd.accept     = (state_r == S_IDLE) && in_valid;
    cmd.move_wr    = (state_r == S_MOVE);
    cmd.emit_first = (state_r == S_START);
    cmd.emit_adv   = (state_r == S_SEND) && !out_stall && !stat.last;
    cmd.finish     = (state_r == S_SEND) && !out_stall && stat.last;
  end

  always_comb begin
    state_nxt    = state_r;
    line_end_nxt = line_end_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          line_end_nxt = in_line_end;
          if (stat.move_ok) begin
            state_nxt = S_MOVE;
          end else if (in_line_end) begin
            state_nxt = S_START;
          end
        end
      end
      S_MOVE:  state_nxt = line_end_r ? S_START : S_IDLE;
      S_START: state_nxt = S_SEND;
      S_SEND: begin
        if (cmd.finish) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      line_end_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      line_end_r <= line_end_nxt;
    end
  end

endmodule

// ----- rtl/kle_dp.sv -----
// Line editor datapath: key codes, the two character stacks, counts and output select.
module kle_dp
  import kle_pkg::*;
#(
  parameter int unsigned CAP = LINE_CAPACITY_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [KEY_W-1:0]     cfg_data,
  input  logic [KEY_W-1:0]     in_key,
  input  kle_cmd_t             cmd,
  output kle_stat_t            stat,
  output logic [KEY_W-1:0]     out_char,
  output logic                 out_last_char,
  output logic                 out_line_empty,
  output logic                 out_overflowed
);

  localparam int unsigned CW = $clog2(CAP + 1);
  localparam int unsigned AW = $clog2(CAP);

  logic [KEY_W-1:0] bs_code_r, left_code_r, right_code_r;

  logic [KEY_W-1:0] left_mem [CAP];
  logic [KEY_W-1:0] right_mem [CAP];
  logic [KEY_W-1:0] rdl_r, rdr_r;

  logic [CW-1:0] lc_r, rc_r;
  logic          ovf_r;
  logic          dir_r;        // 1: pending move is right-to-left
  logic [AW-1:0] idx_r;
  logic          empty_r;
  logic          src_right_r;

  logic          is_bs, is_l, is_r, is_ins;
  logic [CW-1:0] total, lc_m1, rc_m1, r_emit_addr;
  logic          full;
  logic          emit_rd;
  logic [AW-1:0] rd_idx;
  logic          rd_left;
  logic          lre, rre, lwe, rwe;
  logic [AW-1:0] lra, rra;
  logic [KEY_W-1:0] lwd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bs_code_r    <= BACKSPACE_CODE_RST;
      left_code_r  <= LEFT_CODE_RST;
      right_code_r <= RIGHT_CODE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BACKSPACE_CODE: bs_code_r    <= cfg_data;
        CFG_LEFT_CODE:      left_code_r  <= cfg_data;
        CFG_RIGHT_CODE:     right_code_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // backspace wins over left, left over right when codes collide
  assign is_bs  = (in_key == bs_code_r);
  assign is_l   = !is_bs && (in_key == left_code_r);
  assign is_r   = !is_bs && !is_l && (in_key == right_code_r);
  assign is_ins = !is_bs && !is_l && !is_r;

  assign total = lc_r + rc_r;
  assign lc_m1 = lc_r - CW'(1);
  assign rc_m1 = rc_r - CW'(1);
  assign full  = (total >= CW'(CAP));

  assign stat.move_ok = (is_l && (lc_r != '0) && (rc_r < CW'(CAP))) ||
                        (is_r && (rc_r != '0) && (lc_r < CW'(CAP)));

  // Emission walks the left stack bottom-up, then the right stack top-down.
  assign emit_rd     = cmd.emit_first || cmd.emit_adv;
  assign rd_idx      = cmd.emit_first ? '0 : idx_r + AW'(1);
  assign rd_left     = (CW'(rd_idx) < lc_r);
  assign r_emit_addr = total - CW'(1) - CW'(rd_idx);

  assign lre = (cmd.accept && is_l && stat.move_ok) || (emit_rd && rd_left);
  assign rre = (cmd.accept && is_r && stat.move_ok) || (emit_rd && !rd_left);
  assign lra = emit_rd ? rd_idx : lc_m1[AW-1:0];
  assign rra = emit_rd ? r_emit_addr[AW-1:0] : rc_m1[AW-1:0];

  assign lwe = (cmd.accept && is_ins && !full) || (cmd.move_wr && dir_r);
  assign lwd = cmd.move_wr ? rdr_r : in_key;
  assign rwe = cmd.move_wr && !dir_r;

  always_ff @(posedge clk) begin
    if (lwe) begin
      left_mem[lc_r[AW-1:0]] <= lwd;
    end
    if (lre) begin
      rdl_r <= left_mem[lra];
    end
  end

  always_ff @(posedge clk) begin
    if (rwe) begin
      right_mem[rc_r[AW-1:0]] <= rdl_r;
    end
    if (rre) begin
      rdr_r <= right_mem[rra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lc_r  <= '0;
      rc_r  <= '0;
      ovf_r <= 1'b0;
    end else if (cmd.finish) begin
      lc_r  <= '0;
      rc_r  <= '0;
      ovf_r <= 1'b0;
    end else if (cmd.accept) begin
      if (is_bs) begin
        if (lc_r != '0) begin
          lc_r <= lc_m1;
        end
      end else if (is_l) begin
        if (stat.move_ok) begin
          lc_r <= lc_m1;
        end
      end else if (is_r) begin
        if (stat.move_ok) begin
          rc_r <= rc_m1;
        end
      end else if (full) begin
        ovf_r <= 1'b1;
      end else begin
        lc_r <= lc_r + CW'(1);
      end
    end else if (cmd.move_wr) begin
      if (dir_r) begin
        lc_r <= lc_r + CW'(1);
      end else begin
        rc_r <= rc_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      dir_r <= is_r;
    end
    if (cmd.emit_first) begin
      empty_r <= (total == '0);
    end
    if (emit_rd) begin
      idx_r       <= rd_idx;
      src_right_r <= !rd_left;
    end
  end

  assign stat.last      = empty_r || (CW'(idx_r) == total - CW'(1));
  assign out_char       = empty_r ? '0 : (src_right_r ? rdr_r : rdl_r);
  assign out_last_char  = stat.last;
  assign out_line_empty = empty_r;
  assign out_overflowed = ovf_r;

endmodule

// ----- rtl/keystroke_line_editor_unit.sv -----
// Keystroke line editor top level: two-stack gap buffer with sequencer and datapath.
// Insert, backspace and no-op keys are taken in S_IDLE; a cursor move is a stack read, then a write in S_MOVE.
// A line-end key passes through S_START, then one character per cycle leaves while out_stall is low.
// The next key is taken only after the last result of a line has been taken.
// Synchronous active-low reset clears counts, overflow flag, key codes and control state;
// stack contents are not cleared.
module keystroke_line_editor_unit
  import kle_pkg::*;
#(
  parameter int unsigned LINE_CAPACITY = LINE_CAPACITY_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [KEY_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [KEY_W-1:0]     in_key,
  input  logic                 in_line_end,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [KEY_W-1:0]     out_char,
  output logic                 out_last_char,
  output logic                 out_line_empty,
  output logic                 out_overflowed
);

  kle_cmd_t  cmd;
  kle_stat_t stat;

  kle_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_line_end (in_line_end),
    .out_stall   (out_stall),
    .stat        (stat),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .cmd         (cmd)
  );

  kle_dp #(
    .CAP (LINE_CAPACITY)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_key         (in_key),
    .cmd            (cmd),
    .stat           (stat),
    .out_char       (out_char),
    .out_last_char  (out_last_char),
    .out_line_empty (out_line_empty),
    .out_overflowed (out_overflowed)
  );

`ifndef SYNTHESIS
  a_no_intake_while_sending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("key intake open while a line is being sent");

  a_line_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last_char) |=> (!out_valid && !in_stall))
    else $error("editor did not return to intake after the last beat");

  a_empty_line_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_line_empty) |-> (out_last_char && (out_char == '0)))
    else $error("empty line beat is malformed");

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.accept, cmd.move_wr, cmd.emit_first, cmd.emit_adv, cmd.finish}))
    else $error("conflicting datapath commands");
`endif

endmodule
